FILE: sv/itrt_pkg.sv
// ----------------------------------------------------------------------------
// itrt_pkg: shared types and constants for integer to radix text
// Widths, character codes, divider status and digit stack control types.
// ----------------------------------------------------------------------------
package itrt_pkg;

   localparam int VALUE_WIDTH     = 32;
   localparam int REQ_TDATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8;
   localparam int RADIX_WIDTH     = 6;
   localparam int CHAR_WIDTH      = 8;
   localparam int BIT_CNT_WIDTH   = $clog2(VALUE_WIDTH);
   localparam int STACK_IDX_WIDTH = $clog2(VALUE_WIDTH);
   localparam int STACK_CNT_WIDTH = $clog2(VALUE_WIDTH + 1);

   typedef logic [RADIX_WIDTH-1:0] digit_type;
   typedef logic [CHAR_WIDTH-1:0]  char_type;

   localparam digit_type RADIX_MIN   = 6'd2;
   localparam digit_type RADIX_MAX   = 6'd36;
   localparam digit_type RADIX_RESET = 6'd10;
   localparam digit_type DECIMAL_TOP = 6'd10;

   localparam char_type MINUS_CODE  = 8'h2D;
   localparam char_type ZERO_CODE   = 8'h30;
   localparam char_type LETTER_CODE = 8'h61;

   typedef struct packed {
      logic      done;       // one-cycle pulse: remainder and quotient are ready
      logic      more;       // quotient is nonzero, another digit follows
      digit_type remainder;
   } div_status_type;

   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctrl_type;

   function automatic char_type digit_to_char(input digit_type digit);
      char_type code;
      if (digit < DECIMAL_TOP) begin
         code = ZERO_CODE + CHAR_WIDTH'(digit);
      end else begin
         code = LETTER_CODE + CHAR_WIDTH'(digit - DECIMAL_TOP);
      end
      return code;
   endfunction

endpackage

FILE: sv/integer_to_radix_text_top.sv
// ----------------------------------------------------------------------------
// integer_to_radix_text_top: signed integer to ASCII text in radix 2..36
// Renders each request as its text, one character per response transaction.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one transaction carries a signed two's complement value.
//   rsp_*  : one transaction per character, most significant digit first,
//            with a leading '-' for negative values; rsp_tlast marks the
//            final character. Zero yields the single character '0'.
//   csr_*  : writes the radix; values outside 2..36 are dropped and the
//            register keeps its old value. Write only while idle.
// Timing:
//   The bit-serial divider yields one quotient bit per cycle plus a handoff
//   for each digit. With rsp_tready high, a negative value has its '-'
//   registered in the cycle before its first digit.
//   One request is in flight at a time; the next is accepted once the last
//   character sits in the response register.
// Reset: radix returns to 10, the digit stack empties, all channels idle.
// Stall: a held rsp_tready freezes the response register and the emitter.
// ----------------------------------------------------------------------------
module integer_to_radix_text_top (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [itrt_pkg::REQ_TDATA_WIDTH-1:0]   req_tdata,   // [31:0] value
   // response channel
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [itrt_pkg::CHAR_WIDTH-1:0]        rsp_tdata,   // [7:0] character
   output logic                                   rsp_tlast,   // last character
   // radix register write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [itrt_pkg::RADIX_WIDTH-1:0]       csr_data     // [5:0] radix
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_SIGN,
      S_EMIT
   } state_type;

   state_type                            state_ff;
   logic                                 negative_ff;
   itrt_pkg::digit_type                  radix_ff;
   logic                                 rsp_tvalid_ff;
   itrt_pkg::char_type                   rsp_tdata_ff;
   logic                                 rsp_tlast_ff;

   logic [itrt_pkg::VALUE_WIDTH-1:0]     raw_value;
   logic                                 raw_negative;
   logic [itrt_pkg::VALUE_WIDTH-1:0]     magnitude;
   logic                                 req_fire;
   logic                                 out_free;
   logic                                 start_next;
   logic                                 csr_fire;
   itrt_pkg::div_status_type             div_status;
   itrt_pkg::stack_ctrl_type             stack_ctrl;
   itrt_pkg::digit_type                  top_digit;
   logic [itrt_pkg::STACK_CNT_WIDTH-1:0] stack_count;
   logic                                 final_digit;

   // Two's complement magnitude; the most negative value maps to 2^(W-1)
   assign raw_value    = req_tdata[itrt_pkg::VALUE_WIDTH-1:0];
   assign raw_negative = raw_value[itrt_pkg::VALUE_WIDTH-1];
   assign magnitude    = raw_negative ? ('0 - raw_value) : raw_value;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;

   // Keep dividing the quotient while it is nonzero
   assign start_next = (state_ff == S_DIV) && div_status.done && div_status.more;

   assign stack_ctrl.push = (state_ff == S_DIV) && div_status.done;
   assign stack_ctrl.pop  = (state_ff == S_EMIT) && out_free;
   assign final_digit     = (stack_count == itrt_pkg::STACK_CNT_WIDTH'(1));

   itrt_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .start_first (req_fire),
      .start_next  (start_next),
      .dividend    (magnitude),
      .radix       (radix_ff),
      .status      (div_status)
   );

   itrt_digit_stack u_stack (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (stack_ctrl),
      .push_digit (div_status.remainder),
      .top_digit  (top_digit),
      .count      (stack_count)
   );

   // Radix register: drop writes outside the legal range
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= itrt_pkg::RADIX_RESET;
      end else if (csr_fire && csr_data >= itrt_pkg::RADIX_MIN &&
                   csr_data <= itrt_pkg::RADIX_MAX) begin
         radix_ff <= csr_data;
      end
   end

   // Sequencer plus response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         negative_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         rsp_tlast_ff  <= 1'b0;
         rsp_tdata_ff  <= '0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  negative_ff <= raw_negative;
                  state_ff    <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_status.done && !div_status.more) begin
                  state_ff <= S_SIGN;
               end
            end
            S_SIGN: begin
               if (!negative_ff) begin
                  state_ff <= S_EMIT;
               end else if (out_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= itrt_pkg::MINUS_CODE;
                  rsp_tlast_ff  <= 1'b0;
                  state_ff      <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= itrt_pkg::digit_to_char(top_digit);
                  rsp_tlast_ff  <= final_digit;
                  if (final_digit) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_radix_legal: assert property (@(posedge clock) disable iff (reset)
      radix_ff >= itrt_pkg::RADIX_MIN && radix_ff <= itrt_pkg::RADIX_MAX)
      else $error("radix register left its legal range");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("request accepted while a conversion is running");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata == itrt_pkg::MINUS_CODE) |-> !rsp_tlast)
      else $error("minus sign flagged as final character");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide phase");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> stack_count != '0)
      else $error("emitting from an empty digit stack");

endmodule

FILE: sv/itrt_divider.sv
// ----------------------------------------------------------------------------
// itrt_divider: bit-serial restoring divider by the radix
// Shifts one quotient bit per cycle; keeps the quotient for the next digit.
// ----------------------------------------------------------------------------
module itrt_divider (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start_first,
   input  logic                                 start_next,
   input  logic [itrt_pkg::VALUE_WIDTH-1:0]     dividend,
   input  itrt_pkg::digit_type                  radix,
   output itrt_pkg::div_status_type             status
);

   localparam logic [itrt_pkg::BIT_CNT_WIDTH-1:0] LAST_STEP =
      itrt_pkg::BIT_CNT_WIDTH'(itrt_pkg::VALUE_WIDTH - 1);

   logic [itrt_pkg::VALUE_WIDTH-1:0]   quo_ff;
   itrt_pkg::digit_type                rem_ff;
   logic [itrt_pkg::BIT_CNT_WIDTH-1:0] cnt_ff;
   logic                               busy_ff;
   logic                               done_ff;
   logic                               more_ff;

   logic [itrt_pkg::RADIX_WIDTH:0]     trial;
   logic [itrt_pkg::RADIX_WIDTH:0]     diff;
   logic                               qbit;
   itrt_pkg::digit_type                rem_in;

   // One restoring step: bring down the next dividend bit, subtract if it fits
   assign trial  = {rem_ff, quo_ff[itrt_pkg::VALUE_WIDTH-1]};
   assign diff   = trial - {1'b0, radix};
   assign qbit   = (trial >= {1'b0, radix});
   assign rem_in = qbit ? diff[itrt_pkg::RADIX_WIDTH-1:0]
                        : trial[itrt_pkg::RADIX_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         more_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start_first || start_next) begin
            busy_ff <= 1'b1;
            more_ff <= 1'b0;
         end else if (busy_ff) begin
            more_ff <= more_ff | qbit;
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_first) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (start_next) begin
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[itrt_pkg::VALUE_WIDTH-2:0], qbit};
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign status.done      = done_ff;
   assign status.more      = more_ff;
   assign status.remainder = rem_ff;

endmodule

FILE: sv/itrt_digit_stack.sv
// ----------------------------------------------------------------------------
// itrt_digit_stack: last-in first-out store of digits
// Digits arrive least significant first and leave most significant first.
// ----------------------------------------------------------------------------
module itrt_digit_stack (
   input  logic                                   clock,
   input  logic                                   reset,
   input  itrt_pkg::stack_ctrl_type               ctrl,
   input  itrt_pkg::digit_type                    push_digit,
   output itrt_pkg::digit_type                    top_digit,
   output logic [itrt_pkg::STACK_CNT_WIDTH-1:0]   count
);

   itrt_pkg::digit_type                  entries_ff [itrt_pkg::VALUE_WIDTH];
   logic [itrt_pkg::STACK_CNT_WIDTH-1:0] cnt_ff;
   logic [itrt_pkg::STACK_CNT_WIDTH-1:0] top_pos;

   assign top_pos = cnt_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (ctrl.push) begin
         cnt_ff <= cnt_ff + 1'b1;
      end else if (ctrl.pop) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         entries_ff[cnt_ff[itrt_pkg::STACK_IDX_WIDTH-1:0]] <= push_digit;
      end
   end

   assign top_digit = entries_ff[top_pos[itrt_pkg::STACK_IDX_WIDTH-1:0]];
   assign count     = cnt_ff;

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for integer_to_radix_text_top
// Streams signed values into the request channel under several radix
// settings, renders each value's text in a bench-side formatter, and
// compares every response transaction character and tlast in order.
// ----------------------------------------------------------------------------
module tb_top;
   import itrt_pkg::*;

   // run limits
   localparam int LIMIT_CYCLES   = 3_000_000;
   localparam int HOLDOFF_CYCLES = 4000;    // long enough to outlast a radix 2 conversion
   localparam int SETTLE_CYCLES  = 64;
   localparam int RANDOM_PHASES  = 14;
   localparam int PHASE_ITEMS    = 20;
   localparam int MAX_REPORTS    = 50;

   typedef logic [VALUE_WIDTH-1:0] value_type;

   // one expected character of rendered text
   typedef struct packed {
      char_type code;
      logic     last;
   } text_char_type;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   char_type                   rsp_tdata;
   logic                       rsp_tlast;
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   digit_type                  csr_data   = '0;

   string         digit_set = "0123456789abcdefghijklmnopqrstuvwxyz";
   value_type     pending_values[$];   // values waiting for the request driver
   text_char_type expected_text[$];    // characters still owed by the block
   digit_type     radix_setting = RADIX_RESET;
   bit            traffic_gaps  = 1'b1;
   int            req_gap         = 0;
   int            rsp_gap         = 0;
   int            hold_rsp_cycles = 0;
   int            cycle_count     = 0;
   int            mismatch_count  = 0;

   integer_to_radix_text_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Print one line per mismatch, cap the noise, keep counting.
   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_REPORTS) begin
         $display("mismatch at cycle %0d: %s", cycle_count, what);
      end
      mismatch_count++;
   endtask

   // Render a value in the current radix and queue its characters:
   // optional '-', then digits most significant first, tlast on the final one.
   // The magnitude is taken unsigned, so the most negative value needs no repair.
   function automatic void render_value_text(input value_type value);
      value_type magnitude;
      value_type base;
      char_type  digits[$];
      int        idx;
      base      = VALUE_WIDTH'(radix_setting);
      magnitude = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
      do begin
         digits.push_front(char_type'(digit_set[int'(magnitude % base)]));
         magnitude = magnitude / base;
      end while (magnitude != '0);
      if (value[VALUE_WIDTH-1]) begin
         expected_text.push_back(text_char_type'{code: MINUS_CODE, last: 1'b0});
      end
      for (idx = 0; idx < digits.size(); idx++) begin
         expected_text.push_back(text_char_type'{code: digits[idx],
                                                 last: (idx == digits.size() - 1)});
      end
   endfunction

   // Draw a value that stresses digit counts in the given radix: small
   // magnitudes, powers of the radix and their neighbors, shortened random
   // words, the extremes, and plain random words.
   function automatic value_type draw_value(input digit_type base);
      logic [63:0] power;
      value_type   magnitude;
      int          steps;
      power = 64'd1;
      case ($urandom_range(0, 6))
         0: magnitude = VALUE_WIDTH'($urandom_range(0, int'(base) * int'(base)));
         1: begin
            steps = $urandom_range(1, 31);
            repeat (steps) begin
               if (power * base <= 64'h8000_0000) power = power * base;
            end
            magnitude = VALUE_WIDTH'(power) + VALUE_WIDTH'($urandom_range(0, 2)) - 1'b1;
         end
         2: magnitude = VALUE_WIDTH'($urandom) >> $urandom_range(0, VALUE_WIDTH - 1);
         3: begin
            case ($urandom_range(0, 3))
               0:       magnitude = '0;
               1:       magnitude = 'd1;
               2:       magnitude = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
               default: magnitude = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
            endcase
         end
         default: return VALUE_WIDTH'($urandom);
      endcase
      return $urandom_range(0, 1) ? (~magnitude + 1'b1) : magnitude;
   endfunction

   // Hold off on the negative clock edge until every queued value has been
   // accepted and every expected character has come back.
   task automatic wait_drained();
      @(negedge clock);
      while (pending_values.size() != 0 || req_tvalid || expected_text.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Write the radix register; track it only when the value is in range,
   // since the block drops anything outside 2..36. Return on a negative edge.
   task automatic write_radix(input digit_type radix);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= radix;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (radix >= RADIX_MIN && radix <= RADIX_MAX) radix_setting = radix;
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Request driver: render each accepted value, then either hold the
   // current transaction, idle for a burst, or present the next value.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            render_value_text(req_tdata[VALUE_WIDTH-1:0]);
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap = req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_values.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (traffic_gaps && $urandom_range(0, 3) == 0) begin
               req_gap = $urandom_range(0, 10);
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata  <= REQ_TDATA_WIDTH'(pending_values.pop_front());
            end
         end
      end
   end

   // Response ready: stall in random bursts, or hold off entirely while
   // the long hold-off counter runs.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_rsp_cycles > 0) begin
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap = rsp_gap - 1;
         rsp_tready <= 1'b0;
      end else if (traffic_gaps && $urandom_range(0, 4) == 0) begin
         rsp_gap = $urandom_range(0, 10);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Count down the long receiver hold-off.
   always @(posedge clock) begin
      if (hold_rsp_cycles > 0) hold_rsp_cycles <= hold_rsp_cycles - 1;
   end

   // Response monitor: compare each character transaction with the oldest
   // expectation, field by field.
   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_text.size() == 0) begin
            report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                      rsp_tdata, rsp_tlast));
         end else begin
            want = expected_text.pop_front();
            if (rsp_tdata !== want.code) begin
               report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                         rsp_tdata, want.code));
            end
            if (rsp_tlast !== want.last) begin
               report_mismatch($sformatf("tlast %0b, expected %0b", rsp_tlast, want.last));
            end
         end
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   initial begin
      int        phase;
      int        k;
      digit_type base;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed, reset radix of 10: zero, ones, the extremes, a digit
      // boundary and a large round value.
      pending_values.push_back(32'd0);
      pending_values.push_back(32'd1);
      pending_values.push_back(32'hFFFF_FFFF);
      pending_values.push_back(32'h7FFF_FFFF);
      pending_values.push_back(32'h8000_0000);   // most negative value
      pending_values.push_back(32'd9);
      pending_values.push_back(-32'sd10);
      pending_values.push_back(32'd1_000_000_000);
      wait_drained();

      // Top radix: values around the highest digit 'z' and the extremes.
      write_radix(RADIX_MAX);
      pending_values.push_back(32'd35);
      pending_values.push_back(32'd36);
      pending_values.push_back(-32'sd1295);
      pending_values.push_back(32'h7FFF_FFFF);
      pending_values.push_back(32'h8000_0000);
      wait_drained();

      // Bottom radix: the longest texts.
      write_radix(RADIX_MIN);
      pending_values.push_back(32'd0);
      pending_values.push_back(32'd1);
      pending_values.push_back(32'hFFFF_FFFF);
      pending_values.push_back(32'h7FFF_FFFF);
      pending_values.push_back(32'h8000_0000);
      wait_drained();

      // Out-of-range writes must leave radix 2 in place.
      write_radix(6'd0);
      write_radix(6'd1);
      pending_values.push_back(32'd255);
      wait_drained();
      write_radix(6'd37);
      write_radix(6'd63);
      pending_values.push_back(-32'sd255);
      wait_drained();

      // Random phases, each under its own radix; drain between phases so
      // the register only changes while the block is idle.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase >= RANDOM_PHASES - 3) traffic_gaps = 1'b0;
         if (phase % 3 == 2) write_radix(digit_type'($urandom_range(0, 63)));
         if (phase == 0) begin
            base = RADIX_MIN;
         end else if (phase == 1) begin
            base = RADIX_MAX;
         end else begin
            base = digit_type'($urandom_range(RADIX_MIN, RADIX_MAX));
         end
         write_radix(base);
         // Hold the receiver off while values keep coming, so the response
         // register fills and the request channel stalls.
         if (phase == 4) hold_rsp_cycles <= HOLDOFF_CYCLES;
         for (k = 0; k < PHASE_ITEMS; k++) begin
            pending_values.push_back(draw_value(radix_setting));
         end
         wait_drained();
      end

      // Let any stray characters surface before judging the run.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_text.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
